// ===== rtl/core/tmfq_pkg.sv =====
// Shared types, widths and rounding helper for the TRS matrix composer.
// No dependencies; every module of the block refers to it by scoped names.
`timescale 1ns / 1ps

package tmfq_pkg;

  localparam int TRANS_W = 32;
  localparam int QUAT_W  = 16;
  localparam int SCALE_W = 24;
  localparam int PROD_W  = 2 * QUAT_W;
  localparam int TERM_W  = PROD_W + 1;
  localparam int MUL_W   = TERM_W + SCALE_W;
  localparam int RND_W   = MUL_W + 1;
  localparam int OUT_W   = 32;
  localparam int FRAC_SHIFT = 27;
  localparam int N_ENTRY = 9;
  localparam int IN_W    = 3 * TRANS_W + 4 * QUAT_W + 3 * SCALE_W;
  localparam int OUT_DW  = 12 * OUT_W;

  localparam logic signed [TERM_W-1:0] HALF_Q28   = TERM_W'(1) <<< FRAC_SHIFT;
  localparam logic signed [RND_W-1:0]  ROUND_BIAS = RND_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [RND_W-1:0]  OUT_MAX    = RND_W'(32'h7fff_ffff);
  localparam logic signed [RND_W-1:0]  OUT_MIN    = -(RND_W'(1) <<< (OUT_W - 1));

  typedef logic signed [TRANS_W-1:0] trans_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [SCALE_W-1:0] scale_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [MUL_W-1:0]   mul_t;
  typedef logic signed [OUT_W-1:0]   entry_t;

  typedef struct {
    trans_t trans [3];
    quat_t  qx;
    quat_t  qy;
    quat_t  qz;
    quat_t  qw;
    scale_t scale [3];
  } item_t;

  typedef struct {
    trans_t trans [3];
    scale_t scale [3];
    prod_t  xx;
    prod_t  xy;
    prod_t  xz;
    prod_t  xw;
    prod_t  yy;
    prod_t  yz;
    prod_t  yw;
    prod_t  zz;
    prod_t  zw;
  } prods_t;

  // entry index is 3 * row + column
  typedef struct {
    trans_t trans [3];
    scale_t scale [3];
    term_t  term [N_ENTRY];
  } terms_t;

  typedef struct {
    trans_t trans [3];
    mul_t   mul [N_ENTRY];
  } muls_t;

  typedef struct {
    trans_t trans [3];
    entry_t entry [N_ENTRY];
  } result_t;

  // round half up to Q16.16 and saturate to the signed 32-bit range
  function automatic entry_t round_sat(input mul_t p);
    logic signed [RND_W-1:0] r;
    logic signed [RND_W-1:0] sh;
    r  = RND_W'(p) + ROUND_BIAS;
    sh = r >>> FRAC_SHIFT;
    if (sh > OUT_MAX) begin
      return entry_t'(OUT_MAX);
    end else if (sh < OUT_MIN) begin
      return entry_t'(OUT_MIN);
    end else begin
      return sh[OUT_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/tmfq_prod.sv =====
// Stage 1: the nine quaternion component products, registered.
// Depends on tmfq_pkg.
`timescale 1ns / 1ps

module tmfq_prod (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  tmfq_pkg::item_t     in_item,
  output logic                out_valid,
  output tmfq_pkg::prods_t    out_prods
);

  tmfq_pkg::prods_t prods_next;

  always_comb begin
    prods_next.trans = in_item.trans;
    prods_next.scale = in_item.scale;
    prods_next.xx = tmfq_pkg::prod_t'(in_item.qx) * tmfq_pkg::prod_t'(in_item.qx);
    prods_next.xy = tmfq_pkg::prod_t'(in_item.qx) * tmfq_pkg::prod_t'(in_item.qy);
    prods_next.xz = tmfq_pkg::prod_t'(in_item.qx) * tmfq_pkg::prod_t'(in_item.qz);
    prods_next.xw = tmfq_pkg::prod_t'(in_item.qx) * tmfq_pkg::prod_t'(in_item.qw);
    prods_next.yy = tmfq_pkg::prod_t'(in_item.qy) * tmfq_pkg::prod_t'(in_item.qy);
    prods_next.yz = tmfq_pkg::prod_t'(in_item.qy) * tmfq_pkg::prod_t'(in_item.qz);
    prods_next.yw = tmfq_pkg::prod_t'(in_item.qy) * tmfq_pkg::prod_t'(in_item.qw);
    prods_next.zz = tmfq_pkg::prod_t'(in_item.qz) * tmfq_pkg::prod_t'(in_item.qz);
    prods_next.zw = tmfq_pkg::prod_t'(in_item.qz) * tmfq_pkg::prod_t'(in_item.qw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_prods <= prods_next;
    end
  end

endmodule

// ===== rtl/core/tmfq_sum.sv =====
// Stage 2: the nine bracketed rotation terms in Q.28, registered.
// Depends on tmfq_pkg.
`timescale 1ns / 1ps

module tmfq_sum (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  tmfq_pkg::prods_t    in_prods,
  output logic                out_valid,
  output tmfq_pkg::terms_t    out_terms
);

  tmfq_pkg::terms_t terms_next;
  tmfq_pkg::term_t  xx, xy, xz, xw, yy, yz, yw, zz, zw;

  always_comb begin
    xx = tmfq_pkg::TERM_W'(in_prods.xx);
    xy = tmfq_pkg::TERM_W'(in_prods.xy);
    xz = tmfq_pkg::TERM_W'(in_prods.xz);
    xw = tmfq_pkg::TERM_W'(in_prods.xw);
    yy = tmfq_pkg::TERM_W'(in_prods.yy);
    yz = tmfq_pkg::TERM_W'(in_prods.yz);
    yw = tmfq_pkg::TERM_W'(in_prods.yw);
    zz = tmfq_pkg::TERM_W'(in_prods.zz);
    zw = tmfq_pkg::TERM_W'(in_prods.zw);
    terms_next.trans   = in_prods.trans;
    terms_next.scale   = in_prods.scale;
    terms_next.term[0] = tmfq_pkg::HALF_Q28 - yy - zz;
    terms_next.term[1] = xy - zw;
    terms_next.term[2] = xz + yw;
    terms_next.term[3] = xy + zw;
    terms_next.term[4] = tmfq_pkg::HALF_Q28 - xx - zz;
    terms_next.term[5] = yz - xw;
    terms_next.term[6] = xz - yw;
    terms_next.term[7] = yz + xw;
    terms_next.term[8] = tmfq_pkg::HALF_Q28 - xx - yy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_terms <= terms_next;
    end
  end

endmodule

// ===== rtl/core/tmfq_scale.sv =====
// Stage 3: each rotation term times its column scale, exact in Q.44.
// Depends on tmfq_pkg.
`timescale 1ns / 1ps

module tmfq_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  tmfq_pkg::terms_t    in_terms,
  output logic                out_valid,
  output tmfq_pkg::muls_t     out_muls
);

  tmfq_pkg::muls_t muls_next;

  always_comb begin
    muls_next.trans = in_terms.trans;
    for (int k = 0; k < tmfq_pkg::N_ENTRY; k++) begin
      muls_next.mul[k] = tmfq_pkg::MUL_W'(in_terms.term[k])
                       * tmfq_pkg::MUL_W'(in_terms.scale[k % 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_muls <= muls_next;
    end
  end

endmodule

// ===== rtl/core/tmfq_round.sv =====
// Stage 4: round to Q16.16 and saturate; this register is the output register.
// Depends on tmfq_pkg.
`timescale 1ns / 1ps

module tmfq_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  tmfq_pkg::muls_t     in_muls,
  output logic                out_valid,
  output tmfq_pkg::result_t   out_result
);

  tmfq_pkg::result_t result_next;

  always_comb begin
    result_next.trans = in_muls.trans;
    for (int k = 0; k < tmfq_pkg::N_ENTRY; k++) begin
      result_next.entry[k] = tmfq_pkg::round_sat(in_muls.mul[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result <= result_next;
    end
  end

endmodule

// ===== rtl/core/trs_matrix_from_quaternion_core.sv =====
// Top level of the TRS matrix composer: four-stage pipeline and stream ports.
// Depends on tmfq_pkg, tmfq_prod, tmfq_sum, tmfq_scale and tmfq_round.
//
// Takes one transfer per clock unless back-pressure stalls it, and returns one
// result transfer per input, in order. Each input moves through the registered
// stages in turn: component products, rotation sums, scale multiply, rounding.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up under back-pressure and s_tready drops only when all four stages
// hold an item. There is no state between items and no configuration.
`timescale 1ns / 1ps

module trs_matrix_from_quaternion_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // trans_x, trans_y, trans_z, quat_x, quat_y, quat_z, quat_w,
  // scale_x, scale_y, scale_z
  input  logic [tmfq_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // m_r0_c0, m_r0_c1, m_r0_c2, m_r0_c3, m_r1_c0 .. m_r1_c3, m_r2_c0 .. m_r2_c3
  output logic [tmfq_pkg::OUT_DW-1:0] m_tdata
);

  tmfq_pkg::item_t   in_item;
  tmfq_pkg::prods_t  prods;
  tmfq_pkg::terms_t  terms;
  tmfq_pkg::muls_t   muls;
  tmfq_pkg::result_t result;

  logic v1, v2, v3;
  logic en1, en2, en3, en4;

  assign en4 = !m_tvalid || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_comb begin
    in_item.trans[0] = s_tdata[31:0];
    in_item.trans[1] = s_tdata[63:32];
    in_item.trans[2] = s_tdata[95:64];
    in_item.qx       = s_tdata[111:96];
    in_item.qy       = s_tdata[127:112];
    in_item.qz       = s_tdata[143:128];
    in_item.qw       = s_tdata[159:144];
    in_item.scale[0] = s_tdata[183:160];
    in_item.scale[1] = s_tdata[207:184];
    in_item.scale[2] = s_tdata[231:208];
  end

  tmfq_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .en        (en1),
    .in_valid  (s_tvalid),
    .in_item   (in_item),
    .out_valid (v1),
    .out_prods (prods)
  );

  tmfq_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .en        (en2),
    .in_valid  (v1),
    .in_prods  (prods),
    .out_valid (v2),
    .out_terms (terms)
  );

  tmfq_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en3),
    .in_valid  (v2),
    .in_terms  (terms),
    .out_valid (v3),
    .out_muls  (muls)
  );

  tmfq_round u_round (
    .clk        (clk),
    .rst        (rst),
    .en         (en4),
    .in_valid   (v3),
    .in_muls    (muls),
    .out_valid  (m_tvalid),
    .out_result (result)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_tdata[(4 * r + c) * tmfq_pkg::OUT_W +: tmfq_pkg::OUT_W] = result.entry[3 * r + c];
      end
      m_tdata[(4 * r + 3) * tmfq_pkg::OUT_W +: tmfq_pkg::OUT_W] = result.trans[r];
    end
  end

  a_ready_full : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && m_tvalid && !m_tready))
    else $error("input stalled with a free pipeline stage");

  a_stage1_hold : assert property (@(posedge clk) disable iff (rst)
    (v1 && !en2) |=> v1)
    else $error("stage 1 item lost while stage 2 stalled");

  a_stage3_hold : assert property (@(posedge clk) disable iff (rst)
    (v3 && !en4) |=> (v3 && $stable(muls.trans[0])))
    else $error("stage 3 item changed while output stalled");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> (!m_tvalid && !v1 && !v2 && !v3))
    else $error("pipeline not empty after reset");

endmodule

// ===== tb/trs_matrix_from_quaternion_core_test.sv =====
// Self-checking testbench for trs_matrix_from_quaternion_core: directed table, then random
// transforms, predicted in fixed point and compared entry by entry. Depends on tmfq_pkg.
`timescale 1ns / 1ps

module trs_matrix_from_quaternion_core_test;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES = 64;

  // tx, the first field of s_tdata, in the lowest bits
  typedef struct packed {
    tmfq_pkg::scale_t sz;
    tmfq_pkg::scale_t sy;
    tmfq_pkg::scale_t sx;
    tmfq_pkg::quat_t  qw;
    tmfq_pkg::quat_t  qz;
    tmfq_pkg::quat_t  qy;
    tmfq_pkg::quat_t  qx;
    tmfq_pkg::trans_t tz;
    tmfq_pkg::trans_t ty;
    tmfq_pkg::trans_t tx;
  } xform_in_t;

  // entry 4 * row + column, lowest first
  typedef logic [11:0][tmfq_pkg::OUT_W-1:0] rows_t;

  typedef struct {
    xform_in_t item;
    bit        known;
    rows_t     want;
  } table_row_t;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [tmfq_pkg::IN_W-1:0]   s_tdata;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [tmfq_pkg::OUT_DW-1:0] m_tdata;

  rows_t matrix_due [$];
  int    mismatches;
  int    burst_left;
  int    hold_asks;
  int    hold_seen;
  int    hold_left;
  int    rx_mode;
  int    rx_cycle;
  int    idle_cycles;

  string entry_name [12] = '{"m_r0_c0", "m_r0_c1", "m_r0_c2", "m_r0_c3",
                             "m_r1_c0", "m_r1_c1", "m_r1_c2", "m_r1_c3",
                             "m_r2_c0", "m_r2_c1", "m_r2_c2", "m_r2_c3"};

  trs_matrix_from_quaternion_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // term in Q.28 times Q8.16 scale, doubled and rounded half up to Q16.16, saturated
  function automatic logic [tmfq_pkg::OUT_W-1:0] scaled_entry(input longint term,
                                                               input longint s);
    longint r;
    r = (term * s + (64'sd1 <<< (tmfq_pkg::FRAC_SHIFT - 1))) >>> tmfq_pkg::FRAC_SHIFT;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end
    return r[tmfq_pkg::OUT_W-1:0];
  endfunction

  function automatic rows_t compose_trs(input xform_in_t a);
    longint x, y, z, w, sx, sy, sz, half;
    longint xx, xy, xz, xw, yy, yz, yw, zz, zw;
    rows_t m;
    x = longint'(a.qx);
    y = longint'(a.qy);
    z = longint'(a.qz);
    w = longint'(a.qw);
    sx = longint'(a.sx);
    sy = longint'(a.sy);
    sz = longint'(a.sz);
    half = 64'sd1 <<< tmfq_pkg::FRAC_SHIFT;
    xx = x * x; xy = x * y; xz = x * z; xw = x * w;
    yy = y * y; yz = y * z; yw = y * w;
    zz = z * z; zw = z * w;
    m[0]  = scaled_entry(half - yy - zz, sx);
    m[1]  = scaled_entry(xy - zw, sy);
    m[2]  = scaled_entry(xz + yw, sz);
    m[3]  = a.tx;
    m[4]  = scaled_entry(xy + zw, sx);
    m[5]  = scaled_entry(half - xx - zz, sy);
    m[6]  = scaled_entry(yz - xw, sz);
    m[7]  = a.ty;
    m[8]  = scaled_entry(xz - yw, sx);
    m[9]  = scaled_entry(yz + xw, sy);
    m[10] = scaled_entry(half - xx - yy, sz);
    m[11] = a.tz;
    return m;
  endfunction

  function automatic xform_in_t mk(input longint tx, ty, tz, qx, qy, qz, qw, sx, sy, sz);
    xform_in_t v;
    v.tx = tmfq_pkg::trans_t'(tx);
    v.ty = tmfq_pkg::trans_t'(ty);
    v.tz = tmfq_pkg::trans_t'(tz);
    v.qx = tmfq_pkg::quat_t'(qx);
    v.qy = tmfq_pkg::quat_t'(qy);
    v.qz = tmfq_pkg::quat_t'(qz);
    v.qw = tmfq_pkg::quat_t'(qw);
    v.sx = tmfq_pkg::scale_t'(sx);
    v.sy = tmfq_pkg::scale_t'(sy);
    v.sz = tmfq_pkg::scale_t'(sz);
    return v;
  endfunction

  // identity or zero rotation: diagonal is the scale, other rotation entries zero, translation in the last column
  function automatic rows_t diag_only(input longint sx, sy, sz, tx, ty, tz);
    rows_t m;
    m = '0;
    m[0]  = 32'(sx);
    m[5]  = 32'(sy);
    m[10] = 32'(sz);
    m[3]  = 32'(tx);
    m[7]  = 32'(ty);
    m[11] = 32'(tz);
    return m;
  endfunction

  function automatic longint corner();
    case ($urandom_range(0, 4))
      0: return -64'sd2147483648;
      1: return 64'sd2147483647;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic longint clip(input longint v, input int w);
    longint hi;
    hi = (64'sd1 <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic xform_in_t draw_xform();
    xform_in_t v;
    int k;
    k = $urandom_range(0, 9);
    v.tx = $urandom;
    v.ty = $urandom;
    v.tz = $urandom;
    if (k <= 3) begin
      v.qx = tmfq_pkg::quat_t'($urandom);
      v.qy = tmfq_pkg::quat_t'($urandom);
      v.qz = tmfq_pkg::quat_t'($urandom);
      v.qw = tmfq_pkg::quat_t'($urandom);
      v.sx = tmfq_pkg::scale_t'($urandom);
      v.sy = tmfq_pkg::scale_t'($urandom);
      v.sz = tmfq_pkg::scale_t'($urandom);
    end else if (k <= 6) begin
      v.qx = tmfq_pkg::quat_t'($urandom_range(0, 32768) - 16384);
      v.qy = tmfq_pkg::quat_t'($urandom_range(0, 32768) - 16384);
      v.qz = tmfq_pkg::quat_t'($urandom_range(0, 32768) - 16384);
      v.qw = tmfq_pkg::quat_t'($urandom_range(0, 32768) - 16384);
      v.sx = tmfq_pkg::scale_t'($urandom_range(0, 8 << 16) - (4 << 16));
      v.sy = tmfq_pkg::scale_t'($urandom_range(0, 8 << 16) - (4 << 16));
      v.sz = tmfq_pkg::scale_t'($urandom_range(0, 8 << 16) - (4 << 16));
    end else if (k == 7) begin
      v.tx = tmfq_pkg::trans_t'(corner());
      v.ty = tmfq_pkg::trans_t'(corner());
      v.tz = tmfq_pkg::trans_t'(corner());
      v.qx = tmfq_pkg::quat_t'(clip(corner(), tmfq_pkg::QUAT_W));
      v.qy = tmfq_pkg::quat_t'(clip(corner(), tmfq_pkg::QUAT_W));
      v.qz = tmfq_pkg::quat_t'(clip(corner(), tmfq_pkg::QUAT_W));
      v.qw = tmfq_pkg::quat_t'(clip(corner(), tmfq_pkg::QUAT_W));
      v.sx = tmfq_pkg::scale_t'(clip(corner(), tmfq_pkg::SCALE_W));
      v.sy = tmfq_pkg::scale_t'(clip(corner(), tmfq_pkg::SCALE_W));
      v.sz = tmfq_pkg::scale_t'(clip(corner(), tmfq_pkg::SCALE_W));
    end else begin
      // close to a unit rotation with a scale near one
      v.qw = tmfq_pkg::quat_t'(16384 - $urandom_range(0, 4096));
      v.qx = tmfq_pkg::quat_t'($urandom_range(0, 4096) - 2048);
      v.qy = tmfq_pkg::quat_t'($urandom_range(0, 4096) - 2048);
      v.qz = tmfq_pkg::quat_t'($urandom_range(0, 4096) - 2048);
      v.sx = tmfq_pkg::scale_t'(65536 + $urandom_range(0, 8192) - 4096);
      v.sy = tmfq_pkg::scale_t'(65536 + $urandom_range(0, 8192) - 4096);
      v.sz = tmfq_pkg::scale_t'(65536 + $urandom_range(0, 8192) - 4096);
    end
    return v;
  endfunction

  // offer one transfer, with random gaps between bursts when bursty
  task automatic send_item(input xform_in_t v, input rows_t want, input bit bursty);
    if (bursty && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    matrix_due.push_back(want);
  endtask

  always @(posedge clk) begin
    rows_t got;
    rows_t want;
    bit ready_next;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (matrix_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, m_r0_c0 %h", got[0]));
      end else begin
        want = matrix_due.pop_front();
        for (int i = 0; i < 12; i++) begin
          if (got[i] !== want[i]) begin
            flag_mismatch($sformatf("%s got %h want %h", entry_name[i], got[i], want[i]));
          end
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 300 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      ready_next = 1'b0;
    end else begin
      case (rx_mode)
        0: ready_next = 1'b1;
        1: ready_next = 1'($urandom_range(0, 1));
        2: ready_next = (rx_cycle % 7) < 4;
        default: ready_next = $urandom_range(0, 4) == 0;
      endcase
    end
    m_tready <= ready_next;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("trs_matrix_from_quaternion_core_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    table_row_t plan [$];
    table_row_t r;
    xform_in_t v;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    rst = 1'b1;
    mismatches = 0;
    burst_left = 0;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    rx_mode = 0;
    rx_cycle = 0;
    idle_cycles = 0;

    r.item = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    r.known = 1'b1;
    r.want = '0;
    plan.push_back(r);
    r.item = mk(0, 0, 0, 0, 0, 0, 16384, 65536, 65536, 65536);
    r.want = diag_only(65536, 65536, 65536, 0, 0, 0);
    plan.push_back(r);
    r.item = mk(2147483647, -2147483648, -1, 0, 0, 0, 16384, 65536, 65536, 65536);
    r.want = diag_only(65536, 65536, 65536, 2147483647, -2147483648, -1);
    plan.push_back(r);
    r.item = mk(-2147483648, 2147483647, 0, 0, 0, 0, 0, -8388608, -8388608, -8388608);
    r.want = diag_only(-8388608, -8388608, -8388608, -2147483648, 2147483647, 0);
    plan.push_back(r);
    r.item = mk(1, -1, 65536, 0, 0, 0, 0, 8388607, 8388607, 8388607);
    r.want = diag_only(8388607, 8388607, 8388607, 1, -1, 65536);
    plan.push_back(r);
    r.item = mk(0, 0, 0, 0, 0, 0, -16384, 65536, -65536, 32768);
    r.want = diag_only(65536, -65536, 32768, 0, 0, 0);
    plan.push_back(r);

    r.known = 1'b0;
    r.want = '0;
    // component extremes, unnormalised
    r.item = mk(0, 0, 0, -32768, -32768, -32768, -32768, 8388607, 8388607, 8388607);
    plan.push_back(r);
    r.item = mk(0, 0, 0, 32767, 32767, 32767, 32767, -8388608, -8388608, -8388608);
    plan.push_back(r);
    r.item = mk(0, 0, 0, -32768, 32767, -32768, 32767, 8388607, -8388608, 8388607);
    plan.push_back(r);
    r.item = mk(0, 0, 0, 32767, -32768, 32767, -32768, -8388608, 8388607, -8388608);
    plan.push_back(r);
    // half turns about each axis
    r.item = mk(0, 0, 0, 16384, 0, 0, 0, 65536, 65536, 65536);
    plan.push_back(r);
    r.item = mk(0, 0, 0, 0, 16384, 0, 0, 65536, 131072, 196608);
    plan.push_back(r);
    r.item = mk(0, 0, 0, 0, 0, 16384, 0, -65536, 65536, -65536);
    plan.push_back(r);
    // quarter turn about z
    r.item = mk(100, 200, 300, 0, 0, 11585, 11585, 65536, 65536, 65536);
    plan.push_back(r);
    // rounding ties, one positive and one negative
    r.item = mk(0, 0, 0, 8, 8, 0, 0, 1 << 20, 1 << 20, 1 << 20);
    plan.push_back(r);
    r.item = mk(0, 0, 0, 8, 8, 0, 0, -(1 << 20), -(1 << 20), -(1 << 20));
    plan.push_back(r);
    // a non-unit quaternion, then a unit one
    r.item = mk(0, 0, 0, 16384, 16384, 16384, 16384, 196608, 196608, 196608);
    plan.push_back(r);
    r.item = mk(0, 0, 0, 8192, -8192, 8192, 8192, 65536, 65536, 65536);
    plan.push_back(r);
    // alternating bit patterns
    r.item = mk(32'sh5555_5555, -32'sh5555_5556, 32'sh5555_5555, 16'sh5555, -16'sh5556,
                16'sh5555, -16'sh5556, 24'sh55_5555, -24'sh55_5556, 24'sh55_5555);
    plan.push_back(r);
    r.item = mk(-32'sh5555_5556, 32'sh5555_5555, -32'sh5555_5556, -16'sh5556, 16'sh5555,
                -16'sh5556, 16'sh5555, -24'sh55_5556, 24'sh55_5555, -24'sh55_5556);
    plan.push_back(r);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_item(plan[i].item, plan[i].known ? plan[i].want : compose_trs(plan[i].item), 1'b1);
    end

    // pause until the pipeline has drained
    s_tvalid <= 1'b0;
    while (matrix_due.size() != 0) @(posedge clk);

    // long hold-off at the receiver while transfers keep coming
    hold_asks++;
    for (int i = 0; i < 24; i++) begin
      v = draw_xform();
      send_item(v, compose_trs(v), 1'b0);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      v = draw_xform();
      send_item(v, compose_trs(v), 1'b1);
    end
    s_tvalid <= 1'b0;

    while (matrix_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("trs_matrix_from_quaternion_core_test OK");
    end else begin
      $display("trs_matrix_from_quaternion_core_test NOT OK");
    end
    $finish;
  end

endmodule
